[sv/lfd_pkg.sv]
`timescale 1ns / 1ps

package lfd_pkg;

    localparam int WINDOW_SIZE_DEF = 8192;

    // Frame byte count and limit width
    localparam int COUNT_W    = 24;
    // Backward distance 1..8192
    localparam int DIST_W     = 14;
    // Copy length 0..8 (zero means no byte left)
    localparam int LEN_W      = 4;
    // Byte position inside one token's run
    localparam int IDX_W      = 3;
    localparam int MAX_RUN    = 8;

    // Match word layout: length in the low bits, distance above
    localparam logic [2:0] LEN_MASK   = 3'h7;
    localparam int         DIST_SHIFT = 3;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_FETCH,
        ST_RUN,
        ST_EMPTY
    } t_state;

    typedef struct packed {
        logic load;        // take the token in
        logic calc;        // size the run, set the limit flag, start the read pointer
        logic fetch;       // issue one history read
        logic emit;        // produce one byte into the output register
        logic emit_empty;  // produce the result that carries no byte
    } t_cmd;

    typedef struct packed {
        logic out_free;    // output register can take a word this cycle
        logic no_bytes;    // the token produces no byte
        logic last_byte;   // the byte in hand is the last of the run
    } t_status;

endpackage

[sv/lfd_ram.sv]
`timescale 1ns / 1ps

module lfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/lfd_ctrl.sv]
`timescale 1ns / 1ps

module lfd_ctrl import lfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CALC;
            end
            ST_CALC: begin
                n_state = ST_FETCH;
            end
            ST_FETCH: begin
                n_state = i_status.no_bytes ? ST_EMPTY : ST_RUN;
            end
            ST_RUN: begin
                if (i_status.out_free && i_status.last_byte) n_state = ST_IDLE;
            end
            ST_EMPTY: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            ST_RUN: begin
                // read ahead for the next byte while this one goes out
                o_cmd.emit  = i_status.out_free;
                o_cmd.fetch = i_status.out_free && !i_status.last_byte;
            end
            ST_EMPTY: begin
                o_cmd.emit_empty = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[sv/lfd_datapath.sv]
`timescale 1ns / 1ps

module lfd_datapath import lfd_pkg::*; #(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [COUNT_W-1:0]    i_cfg_wdata,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic [IN_USER_W-1:0]  i_in_user,
    input  logic                  i_in_last,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic [OUT_USER_W-1:0] o_out_user,
    output logic                  o_out_last
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int PW = AW + 1;

    // token
    logic               r_lit;
    logic [7:0]         r_lo;
    logic [DIST_W-1:0]  r_dist;
    logic [LEN_W-1:0]   r_len;
    logic               r_last;

    // run control and frame state
    logic [LEN_W-1:0]   r_remain;
    logic [IDX_W-1:0]   r_idx;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW-1:0]      r_wr_ptr;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_limit;
    logic [COUNT_W-1:0] r_max;
    logic [7:0]         r_tokbuf [MAX_RUN];

    // output register
    logic               r_ovalid;
    logic [7:0]         r_obyte;
    logic               r_obyte_vld;
    logic               r_orun;
    logic               r_oframe;
    logic               r_olimit;
    logic [COUNT_W-1:0] r_ototal;

    logic [7:0]         ram_rdata;
    logic [DIST_W-1:0]  in_dist;
    logic [LEN_W-1:0]   in_len;
    logic [COUNT_W:0]   room;
    logic               room_short;
    logic [LEN_W-1:0]   n_remain;
    logic               n_limit;
    logic [PW-1:0]      wr_ext;
    logic [PW-1:0]      dist_ext;
    logic [AW-1:0]      rd_start;
    logic [AW-1:0]      rd_ptr_inc;
    logic [AW-1:0]      wr_ptr_inc;
    logic               from_tok;
    logic               in_frame;
    logic [IDX_W-1:0]   tok_sel;
    logic [7:0]         copy_byte;
    logic [7:0]         new_byte;
    logic               out_load;

    // token decode
    assign in_dist = DIST_W'(i_in_data[IN_DATA_W-1:DIST_SHIFT]) + DIST_W'(1);
    assign in_len  = i_in_user[0] ? (LEN_W'(i_in_data[DIST_SHIFT-1:0] & LEN_MASK) + LEN_W'(1))
                                  : LEN_W'(1);

    // bytes the limit still allows for this token
    assign room       = {1'b0, r_max} - {1'b0, r_out_count};
    assign room_short = room[COUNT_W] || (room[COUNT_W-1:0] < COUNT_W'(r_len));
    assign n_limit    = r_limit || room_short;
    always_comb begin
        if (r_limit || room[COUNT_W]) begin
            n_remain = '0;
        end else if (room_short) begin
            n_remain = room[LEN_W-1:0];
        end else begin
            n_remain = r_len;
        end
    end

    // first read address: write pointer minus distance, modulo the window
    assign wr_ext   = PW'(r_wr_ptr);
    assign dist_ext = PW'(r_dist);
    always_comb begin
        if (wr_ext >= dist_ext) begin
            rd_start = AW'(wr_ext - dist_ext);
        end else begin
            rd_start = AW'(wr_ext + PW'(WINDOW_SIZE) - dist_ext);
        end
    end

    assign rd_ptr_inc = (r_rd_ptr == AW'(WINDOW_SIZE - 1)) ? '0 : r_rd_ptr + AW'(1);
    assign wr_ptr_inc = (r_wr_ptr == AW'(WINDOW_SIZE - 1)) ? '0 : r_wr_ptr + AW'(1);

    // a source inside this token's own run comes from the token buffer,
    // one before the frame start reads zero, the rest from history
    assign from_tok  = r_dist <= DIST_W'(r_idx);
    assign in_frame  = r_out_count >= COUNT_W'(r_dist);
    assign tok_sel   = r_idx - r_dist[IDX_W-1:0];
    assign copy_byte = from_tok ? r_tokbuf[tok_sel] : (in_frame ? ram_rdata : 8'h00);
    assign new_byte  = r_lit ? r_lo : copy_byte;

    assign out_load = i_cmd.emit || i_cmd.emit_empty;

    lfd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (i_cmd.emit),
        .i_waddr (r_wr_ptr),
        .i_wdata (new_byte),
        .i_re    (i_cmd.fetch),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= '0;
            r_out_count <= '0;
            r_limit     <= 1'b0;
            r_wr_ptr    <= '0;
            r_remain    <= '0;
            r_idx       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
                if (i_in_user[1]) begin
                    r_out_count <= '0;
                    r_limit     <= 1'b0;
                    r_wr_ptr    <= '0;
                end
            end
            if (i_cmd.calc) begin
                r_remain <= n_remain;
                r_limit  <= n_limit;
            end
            if (i_cmd.emit) begin
                r_out_count <= r_out_count + COUNT_W'(1);
                r_wr_ptr    <= wr_ptr_inc;
                r_idx       <= r_idx + IDX_W'(1);
                r_remain    <= r_remain - LEN_W'(1);
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lit  <= !i_in_user[0];
            r_lo   <= i_in_data[7:0];
            r_dist <= in_dist;
            r_len  <= in_len;
            r_last <= i_in_last;
        end
        if (i_cmd.calc) begin
            r_rd_ptr <= rd_start;
        end else if (i_cmd.fetch) begin
            r_rd_ptr <= rd_ptr_inc;
        end
        if (i_cmd.emit) begin
            r_tokbuf[r_idx] <= new_byte;
            r_obyte         <= new_byte;
            r_obyte_vld     <= 1'b1;
            r_ototal        <= r_out_count + COUNT_W'(1);
        end else if (i_cmd.emit_empty) begin
            r_obyte         <= 8'h00;
            r_obyte_vld     <= 1'b0;
            r_ototal        <= r_out_count;
        end
        if (out_load) begin
            r_orun   <= i_cmd.emit_empty || (r_remain == LEN_W'(1));
            r_oframe <= r_last && (i_cmd.emit_empty || (r_remain == LEN_W'(1)));
            r_olimit <= r_limit;
        end
    end

    assign o_status.out_free  = !r_ovalid || i_out_ready;
    assign o_status.no_bytes  = (r_remain == '0);
    assign o_status.last_byte = (r_remain == LEN_W'(1));

    assign o_out_valid = r_ovalid;
    assign o_out_data  = {r_ototal, r_obyte};
    assign o_out_user  = {r_olimit, r_orun, r_obyte_vld};
    assign o_out_last  = r_oframe;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_ovalid || i_out_ready))
        else $error("output word overwritten before it was taken");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_idx} + r_remain) <= LEN_W'(MAX_RUN))
        else $error("run position and remaining count exceed one token");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_cmd.load) |=>
            (r_out_count == $past(r_out_count) ||
             r_out_count == $past(r_out_count) + COUNT_W'(1)))
        else $error("frame byte count moved by more than one");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (PW'(r_wr_ptr) < PW'(WINDOW_SIZE)) && (PW'(r_rd_ptr) < PW'(WINDOW_SIZE)))
        else $error("history pointer outside the window");

endmodule

[sv/lzss_flagmap_decompress_13bit.sv]
`timescale 1ns / 1ps
// Sequence: a token is accepted in idle; its run is sized, the history read is
//   primed, then its first result word goes to the output register when free.
// Throughput: one token at a time, the next taken in idle after the last result;
//   1..8 bytes per token (one result if none), paced by the one history read port.
// Reset: synchronous, active low; clears max_length, frame count, limit flag and
//   the output valid flag. History RAM keeps its contents and needs no clearing pass.
module lzss_flagmap_decompress_13bit import lfd_pkg::*; #(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // max_length register write
    input  logic                  i_cfg_we,
    input  logic [COUNT_W-1:0]    i_cfg_wdata,

    // token input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // byte_low, byte_high
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // is_match, first_token
    input  logic                  s_axis_tlast,   // last_token

    // decompressed output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_byte, bytes_total
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // byte_valid, run_end, limit_hit
    output logic                  m_axis_tlast    // frame_end
);

    // The controller sequences one token at a time: take it, size its run
    // against the frame limit, prime the history read, then produce one byte
    // per cycle whenever the output register has room. The datapath holds the
    // frame counters, the history RAM, the token buffer for overlapping copies
    // and the output register that decouples the two stream sides.
    t_cmd    cmd;
    t_status status;

    lfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Limit handling: the run length is clipped to the bytes left below
    // max_length before the first byte goes out, so every word of a token
    // already carries the limit flag as it stands after that token.
    lfd_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule
